// ===== rtl/rpip_pkg.sv =====
// ----------------------------------------------------------------------------
// rpip_pkg: shared types, constants and sine table for the point projector
// Quarter-wave sine table, register indexes and the pipeline item formats.
// ----------------------------------------------------------------------------
package rpip_pkg;

  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int QUARTER    = SINE_DEPTH / 4;
  localparam int QAW        = SINE_AW - 2;

  localparam logic [63:0] TWOPI_Q30 = 64'd6746518852;

  // bearing to table index: k = (a * depth + half turn) / full turn
  localparam int ANGLE_TURN = 3600;
  localparam int ANGLE_HALF = 1800;
  localparam int NW         = $clog2(ANGLE_TURN * SINE_DEPTH + ANGLE_HALF + 1);
  localparam int QW         = SINE_AW + 1;
  localparam logic [63:0] RECIP = (64'd1 << 32) / ANGLE_TURN;
  localparam int RW         = $clog2(RECIP + 1);

  // divider: magnitudes of u, v, z and the quotient bits needed for 13-bit pixels
  localparam int MAGW  = 66;
  localparam int QBITS = 14;
  localparam int DSHW  = MAGW + QBITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // configuration register indexes
  localparam logic [3:0] REG_ROW_U      = 4'd0;
  localparam logic [3:0] REG_ROW_V      = 4'd1;
  localparam logic [3:0] REG_ROW_Z      = 4'd2;
  localparam logic [3:0] REG_OFFSETS_UV = 4'd3;
  localparam logic [3:0] REG_OFFSET_Z   = 4'd4;
  localparam logic [3:0] REG_WIDTH      = 4'd5;
  localparam logic [3:0] REG_HEIGHT     = 4'd6;
  localparam logic [3:0] REG_MAX_RANGE  = 4'd7;

  typedef logic [14:0] qsine_tab_t [0:QUARTER];

  typedef struct packed {
    logic [15:0] range_value;
    logic [13:0] range_rate;
    logic [7:0]  power_db;
  } payload_t;

  typedef struct packed {
    logic [SINE_AW-1:0] k;
    payload_t           pl;
  } item_t;

  function automatic logic [14:0] quarter_sine(input int m);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] prod;
    longint      sum;
    logic [63:0] rnd;
    t    = (64'(m) * TWOPI_Q30) / SINE_DEPTH;
    t2   = (t * t) >> 30;
    term = t;
    sum  = longint'(t);
    for (int n = 1; n <= 5; n++) begin
      prod = (term * t2) >> 30;
      case (n)
        1: term = prod / 6;
        2: term = prod / 20;
        3: term = prod / 42;
        4: term = prod / 72;
        default: term = prod / 110;
      endcase
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    rnd = (64'(sum) + 64'd32768) >> 16;
    if (rnd > 64'd16384) rnd = 64'd16384;
    return rnd[14:0];
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int m = 0; m <= QUARTER; m++) tab[m] = quarter_sine(m);
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  function automatic logic signed [15:0] sine_at(input logic [SINE_AW-1:0] k);
    logic [1:0]     q;
    logic [QAW-1:0] r;
    logic [QAW:0]   idx;
    logic [15:0]    mag;
    q = k[SINE_AW-1 -: 2];
    r = k[QAW-1:0];
    idx = (q[0]) ? (QAW+1)'(QUARTER) - {1'b0, r} : {1'b0, r};
    mag = {1'b0, QSINE[idx]};
    return q[1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== rtl/rpip_front.sv =====
// ----------------------------------------------------------------------------
// rpip_front: detection intake and classification
// Drop detections without track or out of range, map bearing to table index.
// ----------------------------------------------------------------------------
module rpip_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [55:0]           in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic [15:0]           max_range,
  input  logic                  fifo_full,
  output logic                  push,
  output rpip_pkg::item_t       push_item
);

  localparam int PW = rpip_pkg::NW + rpip_pkg::RW;

  logic                        advance;
  logic                        keep;
  logic signed [12:0]          bear_ext;
  logic [11:0]                 angle;
  logic [rpip_pkg::NW-1:0]     n_nxt;
  logic [PW-1:0]               prod;

  logic                        f1_valid_r;
  logic [rpip_pkg::NW-1:0]     f1_n_r;
  rpip_pkg::payload_t          f1_pl_r;

  logic                        f2_valid_r;
  logic [rpip_pkg::NW-1:0]     f2_n_r;
  logic [rpip_pkg::QW-1:0]     f2_q_r;
  rpip_pkg::payload_t          f2_pl_r;

  logic [rpip_pkg::NW-1:0]     qm;
  logic [rpip_pkg::NW-1:0]     rem;
  logic [rpip_pkg::QW-1:0]     k_full;

  assign advance   = !(f2_valid_r && fifo_full);
  assign in_tready = advance;

  assign keep     = (in_tuser != 3'd0) && (in_tdata[15:0] <= max_range);
  assign bear_ext = 13'(signed'(in_tdata[27:16]));
  assign angle    = bear_ext[12] ? 12'(bear_ext + 13'sd3600) : bear_ext[11:0];
  assign n_nxt    = rpip_pkg::NW'({angle, {rpip_pkg::SINE_AW{1'b0}}})
                  + rpip_pkg::NW'(rpip_pkg::ANGLE_HALF);
  assign prod     = PW'(f1_n_r) * PW'(rpip_pkg::RECIP);

  assign qm     = rpip_pkg::NW'(f2_q_r) * rpip_pkg::NW'(rpip_pkg::ANGLE_TURN);
  assign rem    = f2_n_r - qm;
  assign k_full = (rem >= rpip_pkg::NW'(rpip_pkg::ANGLE_TURN)) ? f2_q_r + 1'b1 : f2_q_r;

  assign push                = f2_valid_r && !fifo_full;
  assign push_item.k         = k_full[rpip_pkg::SINE_AW-1:0];
  assign push_item.pl        = f2_pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (advance) begin
      f1_valid_r <= in_tvalid && keep;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_n_r               <= n_nxt;
      f1_pl_r.range_value  <= in_tdata[15:0];
      f1_pl_r.range_rate   <= in_tdata[41:28];
      f1_pl_r.power_db     <= in_tdata[49:42];
      f2_n_r               <= f1_n_r;
      f2_q_r               <= prod[32 +: rpip_pkg::QW];
      f2_pl_r              <= f1_pl_r;
    end
  end

endmodule

// ===== rtl/rpip_fifo.sv =====
// ----------------------------------------------------------------------------
// rpip_fifo: short queue between intake and projection pipeline
// Small register queue with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module rpip_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rpip_pkg::item_t  push_item,
  input  logic             pop,
  output rpip_pkg::item_t  pop_item,
  output logic             full,
  output logic             empty
);

  rpip_pkg::item_t                mem_r [0:rpip_pkg::FIFO_DEPTH-1];
  logic [rpip_pkg::FIFO_AW-1:0]   wr_r;
  logic [rpip_pkg::FIFO_AW-1:0]   rd_r;
  logic [rpip_pkg::FIFO_AW:0]     cnt_r;
  logic                           do_pop;

  assign full     = (cnt_r == (rpip_pkg::FIFO_AW+1)'(rpip_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (rpip_pkg::FIFO_AW+1)'(push) - (rpip_pkg::FIFO_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

endmodule

// ===== rtl/rpip_div.sv =====
// ----------------------------------------------------------------------------
// rpip_div: pipelined signed divider with range check
// Magnitude restoring division, one quotient bit per stage, truncating to zero.
// ----------------------------------------------------------------------------
module rpip_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rpip_pkg::MAGW-1:0] num,
  input  logic signed [rpip_pkg::MAGW-1:0] den,
  output logic [rpip_pkg::QBITS-1:0]       quot,
  output logic                             ok
);

  localparam int MW = rpip_pkg::MAGW;
  localparam int QB = rpip_pkg::QBITS;

  logic [MW-1:0] mag_n;
  logic [MW-1:0] mag_d;

  logic [MW-1:0] rem_r  [0:QB];
  logic [MW-1:0] den_r  [0:QB];
  logic [QB-1:0] q_r    [0:QB];
  logic          neg_r  [0:QB];
  logic          bad_r  [0:QB];

  assign mag_n = num[MW-1] ? MW'(-num) : MW'(num);
  assign mag_d = den[MW-1] ? MW'(-den) : MW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mag_n;
      den_r[0] <= mag_d;
      q_r[0]   <= '0;
      neg_r[0] <= num[MW-1] ^ den[MW-1];
      bad_r[0] <= (den == '0) ||
                  ({{QB{1'b0}}, mag_n} >= {mag_d, {QB{1'b0}}});
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int SH = QB - j;
    logic [rpip_pkg::DSHW-1:0] shd;
    logic                      ge;
    assign shd = rpip_pkg::DSHW'(den_r[j-1]) << SH;
    assign ge  = {{QB{1'b0}}, rem_r[j-1]} >= shd;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_r[j-1] - shd[MW-1:0] : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= ge ? (q_r[j-1] | (QB'(1) << SH)) : q_r[j-1];
        neg_r[j] <= neg_r[j-1];
        bad_r[j] <= bad_r[j-1];
      end
    end
  end

  assign quot = q_r[QB];
  assign ok   = !bad_r[QB] && !(neg_r[QB] && (q_r[QB] != '0));

endmodule

// ===== rtl/rpip_back.sv =====
// ----------------------------------------------------------------------------
// rpip_back: projection pipeline
// Sine lookup, planar coordinates, coefficient products, sums, divide, bounds.
// ----------------------------------------------------------------------------
module rpip_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fifo_empty,
  output logic             fifo_pop,
  input  rpip_pkg::item_t  pop_item,
  input  logic [63:0]      row_u_xy,
  input  logic [63:0]      row_v_xy,
  input  logic [63:0]      row_z_xy,
  input  logic [63:0]      offsets_uv,
  input  logic [31:0]      offset_z,
  input  logic [12:0]      image_width,
  input  logic [12:0]      image_height,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata
);

  localparam int MW   = rpip_pkg::MAGW;
  localparam int DLAT = rpip_pkg::QBITS + 1;

  logic en;

  logic signed [31:0] cux, cuy, cvx, cvy, czx, czy, cu0, cv0, cz0;

  logic                      b0_valid_r;
  logic signed [15:0]        b0_s_r, b0_c_r;
  rpip_pkg::payload_t        b0_pl_r;

  logic                      b1_valid_r;
  logic signed [32:0]        b1_x_r, b1_y_r;
  rpip_pkg::payload_t        b1_pl_r;

  logic                      b2_valid_r;
  logic signed [64:0]        b2_ux_r, b2_uy_r, b2_vx_r, b2_vy_r, b2_zx_r, b2_zy_r;
  rpip_pkg::payload_t        b2_pl_r;

  logic                      b3_valid_r;
  logic signed [MW-1:0]      b3_u_r, b3_v_r, b3_z_r;
  rpip_pkg::payload_t        b3_pl_r;

  logic                      d_valid_r [1:DLAT];
  rpip_pkg::payload_t        d_pl_r    [1:DLAT];

  logic [rpip_pkg::QBITS-1:0] qx, qy;
  logic                       okx, oky;
  logic                       keep;

  logic                       out_valid_r;
  logic [63:0]                out_data_r;

  assign en       = !out_valid_r || out_tready;
  assign fifo_pop = en && !fifo_empty;

  assign cux = $signed(row_u_xy[31:0]);
  assign cuy = $signed(row_u_xy[63:32]);
  assign cvx = $signed(row_v_xy[31:0]);
  assign cvy = $signed(row_v_xy[63:32]);
  assign czx = $signed(row_z_xy[31:0]);
  assign czy = $signed(row_z_xy[63:32]);
  assign cu0 = $signed(offsets_uv[31:0]);
  assign cv0 = $signed(offsets_uv[63:32]);
  assign cz0 = $signed(offset_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_valid_r <= 1'b0;
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
      b3_valid_r <= 1'b0;
      for (int i = 1; i <= DLAT; i++) d_valid_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b0_valid_r <= !fifo_empty;
      b1_valid_r <= b0_valid_r;
      b2_valid_r <= b1_valid_r;
      b3_valid_r <= b2_valid_r;
      d_valid_r[1] <= b3_valid_r;
      for (int i = 2; i <= DLAT; i++) d_valid_r[i] <= d_valid_r[i-1];
      out_valid_r <= d_valid_r[DLAT] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_s_r  <= rpip_pkg::sine_at(pop_item.k);
      b0_c_r  <= rpip_pkg::sine_at(pop_item.k + rpip_pkg::SINE_AW'(rpip_pkg::QUARTER));
      b0_pl_r <= pop_item.pl;

      b1_x_r  <= $signed({1'b0, b0_pl_r.range_value}) * b0_s_r;
      b1_y_r  <= $signed({1'b0, b0_pl_r.range_value}) * b0_c_r;
      b1_pl_r <= b0_pl_r;

      b2_ux_r <= cux * b1_x_r;
      b2_uy_r <= cuy * b1_y_r;
      b2_vx_r <= cvx * b1_x_r;
      b2_vy_r <= cvy * b1_y_r;
      b2_zx_r <= czx * b1_x_r;
      b2_zy_r <= czy * b1_y_r;
      b2_pl_r <= b1_pl_r;

      b3_u_r  <= MW'(b2_ux_r) + MW'(b2_uy_r) + (MW'(cu0) <<< 14);
      b3_v_r  <= MW'(b2_vx_r) + MW'(b2_vy_r) + (MW'(cv0) <<< 14);
      b3_z_r  <= MW'(b2_zx_r) + MW'(b2_zy_r) + (MW'(cz0) <<< 14);
      b3_pl_r <= b2_pl_r;

      d_pl_r[1] <= b3_pl_r;
      for (int i = 2; i <= DLAT; i++) d_pl_r[i] <= d_pl_r[i-1];

      out_data_r <= {d_pl_r[DLAT].power_db, d_pl_r[DLAT].range_rate,
                     d_pl_r[DLAT].range_value, qy[12:0], qx[12:0]};
    end
  end

  rpip_div u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (b3_u_r),
    .den  (b3_z_r),
    .quot (qx),
    .ok   (okx)
  );

  rpip_div u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (b3_v_r),
    .den  (b3_z_r),
    .quot (qy),
    .ok   (oky)
  );

  assign keep = okx && oky &&
                (qx <= rpip_pkg::QBITS'(image_width)) &&
                (qy <= rpip_pkg::QBITS'(image_height));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/radar_point_image_projection.sv =====
// ----------------------------------------------------------------------------
// radar_point_image_projection: radar detection to image pixel projector
// Filters detections, projects them through a folded camera model, bounds check.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake             | content
//   in_      | slave     | in_tvalid/in_tready   | one detection
//   out_     | master    | out_tvalid/out_tready | one pixel with passthrough
//   cfg_     | slave     | cfg_valid/cfg_ready   | register index and value
//
// One detection per cycle sustained while the output is not stalled; the path runs
// through intake, queue, products and sums, then the 14 one-bit stages of the pixel dividers.
// Synchronous active-low reset clears valids, queue and registers to defaults.
// An output stall freezes the projection pipeline; intake keeps going until the
// four-entry queue fills. The configuration port is always ready.
// ----------------------------------------------------------------------------
module radar_point_image_projection (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // range_value[15:0], bearing[27:16], range_rate[41:28], power_db[49:42]
  input  logic [55:0] in_tdata,
  // track_status[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_x[12:0], pixel_y[25:13], out_range[41:26], out_rate[55:42], out_power[63:56]
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] row_u_r, row_v_r, row_z_r, offsets_uv_r;
  logic [31:0] offset_z_r;
  logic [12:0] width_r, height_r;
  logic [15:0] max_range_r;

  logic             push, pop, full, empty;
  rpip_pkg::item_t  push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_u_r      <= '0;
      row_v_r      <= '0;
      row_z_r      <= 64'h0001_0000_0000_0000;
      offsets_uv_r <= '0;
      offset_z_r   <= '0;
      width_r      <= 13'd1920;
      height_r     <= 13'd1200;
      max_range_r  <= 16'd1500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpip_pkg::REG_ROW_U:      row_u_r      <= cfg_data;
        rpip_pkg::REG_ROW_V:      row_v_r      <= cfg_data;
        rpip_pkg::REG_ROW_Z:      row_z_r      <= cfg_data;
        rpip_pkg::REG_OFFSETS_UV: offsets_uv_r <= cfg_data;
        rpip_pkg::REG_OFFSET_Z:   offset_z_r   <= cfg_data[31:0];
        rpip_pkg::REG_WIDTH:      width_r      <= cfg_data[12:0];
        rpip_pkg::REG_HEIGHT:     height_r     <= cfg_data[12:0];
        rpip_pkg::REG_MAX_RANGE:  max_range_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rpip_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .max_range (max_range_r),
    .fifo_full (full),
    .push      (push),
    .push_item (push_item)
  );

  rpip_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  rpip_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_empty   (empty),
    .fifo_pop     (pop),
    .pop_item     (pop_item),
    .row_u_xy     (row_u_r),
    .row_v_xy     (row_v_r),
    .row_z_xy     (row_z_r),
    .offsets_uv   (offsets_uv_r),
    .offset_z     (offset_z_r),
    .image_width  (width_r),
    .image_height (height_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// ===== rtl/rpip_checker.sv =====
// ----------------------------------------------------------------------------
// rpip_checker: port-level checks for the point projector
// Reset behavior, output hold under stall and configuration acceptance.
// ----------------------------------------------------------------------------
module rpip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled transaction changed");

  a_cfg_taken: assert property (@(posedge clk) cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind radar_point_image_projection rpip_checker u_rpip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// ===== tb/tb_radar_point_image_projection.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radar_point_image_projection: self-checking bench for the point projector
// Drives radar detections under several register settings, predicts each pixel
// (or the drop of the detection) from a local fixed-point projection, and
// compares every output transaction in order while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_radar_point_image_projection;

  typedef struct {
    logic [15:0] range_value;
    logic [11:0] bearing;
    logic [2:0]  status;
    logic [13:0] rate;
    logic [7:0]  power;
  } detection_t;

  typedef struct {
    logic [12:0] px;
    logic [12:0] py;
    logic [15:0] range_value;
    logic [13:0] rate;
    logic [7:0]  power;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [63:0] cfg_data;

  radar_point_image_projection i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // local copy of the registers
  logic [63:0] coef_u, coef_v, coef_z, offs_uv;
  logic [31:0] offs_z;
  logic [12:0] img_w, img_h;
  logic [15:0] range_limit;

  longint      qsine [0:256];
  detection_t  pending_q[$];
  pixel_t      pixel_q[$];
  detection_t  cur_det;
  int          n_accepted, n_pixels, n_errors, hold_cnt;
  bit          hold_done, sender_paused, calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint quarter_sine_q14(int m);
    bit [63:0] t, t2, term;
    longint    acc;
    t    = 64'(m) * 64'd6746518852 / 64'd1024;
    t2   = (t * t) >> 30;
    term = t;
    acc  = longint'(t);
    for (int n = 1; n <= 5; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = longint'((64'(acc) + 64'd32768) >> 16);
    if (acc > 16384) acc = 16384;
    return acc;
  endfunction

  function automatic longint sine_q14(int k);
    int q, r;
    k = k % 1024;
    q = k / 256;
    r = k % 256;
    case (q)
      0: return qsine[r];
      1: return qsine[256 - r];
      2: return -qsine[r];
      default: return -qsine[256 - r];
    endcase
  endfunction

  function automatic longint s32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // returns 1 and the pixel when the detection lands inside the image
  function automatic bit project_detection(detection_t d, output pixel_t p);
    int     b, k;
    longint x, y, u, v, z, px, py;
    if (d.status == 0 || d.range_value > range_limit) return 0;
    b = int'($signed(d.bearing));
    if (b < 0) b += 3600;
    k = ((b * 1024 + 1800) / 3600) % 1024;
    x = longint'(d.range_value) * sine_q14(k);
    y = longint'(d.range_value) * sine_q14(k + 256);
    u = s32(coef_u[31:0]) * x + s32(coef_u[63:32]) * y + s32(offs_uv[31:0]) * 16384;
    v = s32(coef_v[31:0]) * x + s32(coef_v[63:32]) * y + s32(offs_uv[63:32]) * 16384;
    z = s32(coef_z[31:0]) * x + s32(coef_z[63:32]) * y + s32(offs_z) * 16384;
    if (z == 0) return 0;
    px = u / z;
    py = v / z;
    if (px < 0 || px > longint'(img_w) || py < 0 || py > longint'(img_h)) return 0;
    p.px = px[12:0];
    p.py = py[12:0];
    p.range_value = d.range_value;
    p.rate = d.rate;
    p.power = d.power;
    return 1;
  endfunction

  // input driver
  always @(posedge clk) begin
    pixel_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        n_accepted++;
        if (project_detection(cur_det, p)) pixel_q = {pixel_q, p};
      end
      calm = n_accepted >= 400 && n_accepted < 600;
      if (!(in_tvalid && !in_tready)) begin
        if (pending_q.size() == 0 || sender_paused || (!calm && $urandom_range(99) < 18)) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_det = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, cur_det.power, cur_det.rate, cur_det.bearing,
                       cur_det.range_value};
          in_tuser <= cur_det.status;
        end
      end
    end
  end

  // output ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && n_accepted >= 900) begin
      hold_done <= 1'b1;
      hold_cnt <= 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || $urandom_range(99) >= 18;
    end
  end

  // output monitor
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_pixels++;
      if (pixel_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected pixel transaction %h", out_tdata);
      end else begin
        e = pixel_q.pop_front();
        if (out_tdata[12:0] !== e.px || out_tdata[25:13] !== e.py ||
            out_tdata[41:26] !== e.range_value || out_tdata[55:42] !== e.rate ||
            out_tdata[63:56] !== e.power) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp px=%0d py=%0d rng=%0d rate=%h pwr=%h, got %0d %0d %0d %h %h",
                     e.px, e.py, e.range_value, e.rate, e.power, out_tdata[12:0],
                     out_tdata[25:13], out_tdata[41:26], out_tdata[55:42],
                     out_tdata[63:56]);
        end
      end
    end
  end

  task automatic queue_det(detection_t d);
    pending_q = {pending_q, d};
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rpip_pkg::REG_ROW_U:      coef_u = val;
      rpip_pkg::REG_ROW_V:      coef_v = val;
      rpip_pkg::REG_ROW_Z:      coef_z = val;
      rpip_pkg::REG_OFFSETS_UV: offs_uv = val;
      rpip_pkg::REG_OFFSET_Z:   offs_z = val[31:0];
      rpip_pkg::REG_WIDTH:      img_w = val[12:0];
      rpip_pkg::REG_HEIGHT:     img_h = val[12:0];
      rpip_pkg::REG_MAX_RANGE:  range_limit = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    sender_paused = 1'b0;
    while (pending_q.size() != 0 || in_tvalid || pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] q16(int a, int b);
    return {32'(b) << 16, 32'(a) << 16};
  endfunction

  // plausible camera: px = f*tan + cx, py = cy + k/r_cos
  task automatic camera_setting(int f, int cx, int cy, int voff, int zoff, int w, int h,
                                int rmax);
    write_reg(rpip_pkg::REG_ROW_U, q16(f, cx));
    write_reg(rpip_pkg::REG_ROW_V, q16(0, cy));
    write_reg(rpip_pkg::REG_ROW_Z, q16(0, 1));
    write_reg(rpip_pkg::REG_OFFSETS_UV, {32'(voff) << 16, 32'd0});
    write_reg(rpip_pkg::REG_OFFSET_Z, 64'(32'(zoff) << 16));
    write_reg(rpip_pkg::REG_WIDTH, 64'(w));
    write_reg(rpip_pkg::REG_HEIGHT, 64'(h));
    write_reg(rpip_pkg::REG_MAX_RANGE, 64'(rmax));
  endtask

  function automatic detection_t make_det(int r, int b, int st, int rt, int pw);
    detection_t d;
    d.range_value = 16'(r);
    d.bearing = 12'(b);
    d.status = 3'(st);
    d.rate = 14'(rt);
    d.power = 8'(pw);
    return d;
  endfunction

  function automatic detection_t random_det();
    detection_t d;
    d = make_det($urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(99) < 85) begin
      if (d.status == 0) d.status = 3'($urandom_range(1, 7));
      d.range_value = 16'($urandom_range(0, range_limit));
      if ($urandom_range(99) < 75) d.bearing = 12'($urandom_range(0, 1600) - 800);
    end
    return d;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) queue_det(random_det());
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_accepted = 0;
    n_pixels = 0;
    n_errors = 0;
    hold_cnt = 0;
    hold_done = 0;
    sender_paused = 0;
    calm = 0;
    for (int m = 0; m <= 256; m++) qsine[m] = quarter_sine_q14(m);
    coef_u = '0;
    coef_v = '0;
    coef_z = 64'd281474976710656;
    offs_uv = '0;
    offs_z = '0;
    img_w = 13'd1920;
    img_h = 13'd1200;
    range_limit = 16'd1500;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: trivial projection, range and status filtering
    queue_det(make_det(1000, 0, 0, 5, 5));
    queue_det(make_det(1501, 0, 1, 5, 5));
    queue_det(make_det(1500, 0, 7, 8191, 127));
    queue_det(make_det(0, 0, 1, -8192, -128));
    queue_det(make_det(800, 900, 2, 0, 0));
    queue_det(make_det(800, -1800, 3, 1, -1));
    wait_drained();

    // realistic camera: edges, wrap, zero depth, out of view
    camera_setting(1000, 960, 600, 20000, -100, 1920, 1200, 65535);
    queue_det(make_det(65535, 0, 1, 8191, 127));
    queue_det(make_det(100, 0, 4, -8192, -128));
    queue_det(make_det(2000, 1800, 5, 3, 3));
    queue_det(make_det(2000, -1800, 5, 3, 3));
    queue_det(make_det(3000, 2047, 6, 3, 3));
    queue_det(make_det(3000, -2048, 6, 3, 3));
    queue_det(make_det(3000, 800, 1, 3, 3));
    queue_det(make_det(3000, -800, 1, 3, 3));
    queue_det(make_det(3000, 300, 1, 3, 3));
    queue_det(make_det(3000, -300, 1, 3, 3));
    queue_det(make_det(50, 0, 1, 3, 3));
    queue_det(make_det(3000, 0, 0, 3, 3));
    wait_drained();
    random_phase(300);

    // image size and range extremes
    camera_setting(500, 4000, 4000, 0, 0, 8191, 8191, 0);
    queue_det(make_det(0, 0, 1, 1, 1));
    queue_det(make_det(1, 0, 1, 1, 1));
    wait_drained();
    camera_setting(0, 0, 0, 0, 0, 0, 0, 65535);
    random_phase(100);
    camera_setting(1, 1, 1, 0, 0, 1, 1, 65535);
    random_phase(100);

    // randomized cameras
    for (int ph = 0; ph < 3; ph++) begin
      camera_setting($urandom_range(200, 2000), $urandom_range(0, 2000),
                     $urandom_range(0, 1500), $urandom_range(0, 30000) - 15000,
                     $urandom_range(0, 200) - 100, $urandom_range(1, 8191),
                     $urandom_range(1, 8191), $urandom_range(0, 65535));
      random_phase(250);
    end

    // raw register values, including ignored indexes
    write_reg(rpip_pkg::REG_ROW_U, {$urandom, $urandom});
    write_reg(rpip_pkg::REG_ROW_V, {$urandom, $urandom});
    write_reg(rpip_pkg::REG_ROW_Z, {$urandom, $urandom});
    write_reg(rpip_pkg::REG_OFFSETS_UV, {$urandom, $urandom});
    write_reg(rpip_pkg::REG_OFFSET_Z, {$urandom, $urandom});
    write_reg(rpip_pkg::REG_MAX_RANGE, 64'hFFFF);
    for (int i = 0; i < 4; i++)
      write_reg(4'(rpip_pkg::REG_MAX_RANGE + 1 + $urandom_range(0, 7)), {$urandom, $urandom});
    random_phase(100);

    camera_setting(1200, 960, 600, 10000, 0, 1920, 1200, 40000);
    random_phase(180);

    $display("run covered %0d detections over reset, fixed, random and raw settings,",
             n_accepted);
    $display("%0d projected pixels checked, %0d mismatches", n_pixels, n_errors);
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== radar_point_image_projection.f =====
rtl/rpip_pkg.sv
rtl/rpip_front.sv
rtl/rpip_fifo.sv
rtl/rpip_div.sv
rtl/rpip_back.sv
rtl/radar_point_image_projection.sv
rtl/rpip_checker.sv
tb/tb_radar_point_image_projection.sv
